// ----- sv/tlt_pkg.sv -----
package tlt_pkg;

    // Command codes of the input item.
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_GEN    = 2'd1;
    localparam logic [1:0] CMD_RENEW  = 2'd2;

    // Status codes of the result item.
    localparam logic [2:0] STS_CREATED  = 3'd0;
    localparam logic [2:0] STS_LIVE     = 3'd1;
    localparam logic [2:0] STS_RENEWED  = 3'd2;
    localparam logic [2:0] STS_NOTFOUND = 3'd3;
    localparam logic [2:0] STS_FULL     = 3'd4;
    localparam logic [2:0] STS_TICK     = 3'd5;

    // Lease length after reset.
    localparam logic [15:0] LEASE_RESET = 16'd10;

    // One table entry as stored in the entry memory.
    typedef struct packed {
        logic        used;
        logic [63:0] key;
        logic [31:0] created;
        logic [31:0] expiry;
        logic [15:0] renewals;
    } t_entry;

    // Result fields of one command.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] expiry;
        logic [15:0] renewals;
        logic [31:0] created;
    } t_result;

    // What the scan has found so far.
    typedef struct packed {
        logic hit;
        logic free;
    } t_scan_flags;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_OUT
    } t_state;

    // Saturating 32-bit add.
    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ----- sv/tlt_entry_ram.sv -----
module tlt_entry_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  tlt_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output tlt_pkg::t_entry o_rdata
);
    import tlt_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/tlt_scan.sv -----
module tlt_scan #(
    parameter int AW = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_rd_valid,
    input  logic [AW-1:0]        i_rd_idx,
    input  tlt_pkg::t_entry      i_rd_data,
    input  logic [63:0]          i_key,
    input  logic [31:0]          i_now,
    output tlt_pkg::t_scan_flags o_flags,
    output logic [AW-1:0]        o_hit_idx,
    output logic [AW-1:0]        o_free_idx,
    output tlt_pkg::t_entry      o_hit_entry
);
    import tlt_pkg::*;

    t_scan_flags r_flags;
    logic [AW-1:0] r_hit_idx;
    logic [AW-1:0] r_free_idx;
    t_entry r_hit_entry;
    logic w_live;
    logic w_hit;
    logic w_free;

    // An expired entry counts as free: once expired it can never come back to life.
    assign w_live = i_rd_data.used && (i_rd_data.expiry >= i_now);
    assign w_hit  = w_live && (i_rd_data.key == i_key);
    assign w_free = !w_live;

    // Flags are control state; clear them at the start of each scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_flags <= '0;
        end else if (i_rd_valid) begin
            if (w_hit) begin
                r_flags.hit <= 1'b1;
            end
            if (w_free) begin
                r_flags.free <= 1'b1;
            end
        end
    end

    // Keep the lowest-numbered hit and free entry.
    always_ff @(posedge i_clk) begin
        if (i_rd_valid && !i_start) begin
            if (w_hit && !r_flags.hit) begin
                r_hit_idx   <= i_rd_idx;
                r_hit_entry <= i_rd_data;
            end
            if (w_free && !r_flags.free) begin
                r_free_idx <= i_rd_idx;
            end
        end
    end

    assign o_flags     = r_flags;
    assign o_hit_idx   = r_hit_idx;
    assign o_free_idx  = r_free_idx;
    assign o_hit_entry = r_hit_entry;

endmodule

// ----- sv/token_lease_table.sv -----
// Channel   Direction  Handshake            Payload
// command   in         i_valid / o_stall    i_cmd, i_token_key
// result    out        o_valid / i_stall    o_status, o_lease_end, o_renew_total,
//                                           o_lease_start
// config    in         i_cfg_we             i_cfg_data (lease_ticks)
//
// A tick or an unused command passes through the hand-off state to the result register,
// and the command channel opens again as that result is registered.
// Generate and renew scan the entry memory one entry a cycle through its single
// read port, then pass through the decision and hand-off states before their result
// is registered; the command channel opens again as that result is registered.
// After reset a clearing pass writes every entry once with the command channel
// stalled; configuration writes are taken throughout.
// A stalled result register holds the next command in its final state.
module token_lease_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [63:0] i_token_key,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_lease_end,
    output logic [15:0] o_renew_total,
    output logic [31:0] o_lease_start,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    import tlt_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW:0] LAST_ADDR = (AW+1)'(TABLE_ENTRIES - 1);
    localparam logic [AW:0] END_ADDR  = (AW+1)'(TABLE_ENTRIES);

    t_state r_state, n_state;
    logic [AW:0] r_addr, n_addr;
    logic [31:0] r_now, n_now;
    logic [15:0] r_lease;
    logic [1:0] r_cmd, n_cmd;
    logic [63:0] r_key, n_key;
    t_result r_res, n_res;
    t_result r_out, n_out;
    logic r_o_valid, n_o_valid;
    logic r_rd_valid;
    logic [AW-1:0] r_rd_idx;

    logic w_we;
    logic [AW-1:0] w_waddr;
    t_entry w_wdata;
    logic w_issue;
    logic w_start;
    t_entry w_rdata;
    t_scan_flags w_flags;
    logic [AW-1:0] w_hit_idx;
    logic [AW-1:0] w_free_idx;
    t_entry w_hit_entry;
    t_entry w_renewed;

    tlt_entry_ram #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    tlt_scan #(
        .AW (AW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_rd_valid  (r_rd_valid),
        .i_rd_idx    (r_rd_idx),
        .i_rd_data   (w_rdata),
        .i_key       (r_key),
        .i_now       (r_now),
        .o_flags     (w_flags),
        .o_hit_idx   (w_hit_idx),
        .o_free_idx  (w_free_idx),
        .o_hit_entry (w_hit_entry)
    );

    // The renewed entry: expiry and count both saturate.
    always_comb begin
        w_renewed = w_hit_entry;
        w_renewed.expiry = sat_add32(w_hit_entry.expiry, {16'd0, r_lease});
        w_renewed.renewals = (w_hit_entry.renewals == 16'hFFFF) ?
                             w_hit_entry.renewals : w_hit_entry.renewals + 16'd1;
    end

    // Sequencer: clearing pass, command decode, scan, decision and result hand-off.
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_now     = r_now;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_res     = r_res;
        n_out     = r_out;
        n_o_valid = r_o_valid;
        w_we      = 1'b0;
        w_waddr   = r_addr[AW-1:0];
        w_wdata   = '0;
        w_issue   = 1'b0;
        w_start   = 1'b0;

        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                w_we   = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_cmd = i_cmd;
                    n_key = i_token_key;
                    n_res = '0;
                    n_res.status = STS_TICK;
                    if (i_cmd == CMD_GEN || i_cmd == CMD_RENEW) begin
                        w_start = 1'b1;
                        n_addr  = '0;
                        n_state = ST_SCAN;
                    end else begin
                        if (i_cmd == CMD_TICK && r_now != 32'hFFFF_FFFF) begin
                            n_now = r_now + 32'd1;
                        end
                        n_state = ST_OUT;
                    end
                end
            end
            ST_SCAN: begin
                if (r_addr != END_ADDR) begin
                    w_issue = 1'b1;
                    n_addr  = r_addr + 1'b1;
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = ST_OUT;
                n_res   = '0;
                if (r_cmd == CMD_GEN) begin
                    priority if (w_flags.hit) begin
                        n_res.status = STS_LIVE;
                    end else if (w_flags.free) begin
                        w_we             = 1'b1;
                        w_waddr          = w_free_idx;
                        w_wdata.used     = 1'b1;
                        w_wdata.key      = r_key;
                        w_wdata.created  = r_now;
                        w_wdata.expiry   = sat_add32(r_now, {16'd0, r_lease});
                        w_wdata.renewals = '0;
                        n_res.status     = STS_CREATED;
                        n_res.expiry     = w_wdata.expiry;
                        n_res.created    = r_now;
                    end else begin
                        n_res.status = STS_FULL;
                    end
                end else begin
                    if (w_flags.hit) begin
                        w_we           = 1'b1;
                        w_waddr        = w_hit_idx;
                        w_wdata        = w_renewed;
                        n_res.status   = STS_RENEWED;
                        n_res.expiry   = w_renewed.expiry;
                        n_res.renewals = w_renewed.renewals;
                        n_res.created  = w_renewed.created;
                    end else begin
                        n_res.status = STS_NOTFOUND;
                    end
                end
            end
            ST_OUT: begin
                if (!r_o_valid || !i_stall) begin
                    n_out     = r_res;
                    n_o_valid = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_addr     <= '0;
            r_now      <= '0;
            r_o_valid  <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_now      <= n_now;
            r_o_valid  <= n_o_valid;
            r_rd_valid <= w_issue;
        end
    end

    // Lease length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lease <= LEASE_RESET;
        end else if (i_cfg_we) begin
            r_lease <= i_cfg_data;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_res    <= n_res;
        r_out    <= n_out;
        r_rd_idx <= r_addr[AW-1:0];
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_o_valid;
    assign o_status      = r_out.status;
    assign o_lease_end   = r_out.expiry;
    assign o_renew_total = r_out.renewals;
    assign o_lease_start = r_out.created;

    // Every accepted command keeps the channel stalled in the next cycle.
    a_accept_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("command accepted twice in a row");

    // A new result appears only out of the hand-off state.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_OUT))
        else $error("result raised outside hand-off");

    // The memory is never written while it is being scanned.
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !w_we)
        else $error("entry write during scan");

    // Only created and renewed results carry a nonzero expiry.
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STS_CREATED && o_status != STS_RENEWED)
            |-> (o_lease_end == 32'd0 && o_renew_total == 16'd0))
        else $error("fields set on a result without entry");

endmodule
